/* src/htd_pkg.sv */
// Shared types and constants for the Huffman tree decoder.
// Used by every module of the block; depends on nothing else.
package htd_pkg;

    localparam int CODE_W = 14;
    localparam int LEN_W = 4;
    localparam int SYM_W = 8;
    localparam int BYTE_W = 8;

    localparam int NODE_COUNT_DEF = 512;
    localparam int MAX_CODE_LEN_DEF = 14;

    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW = 1;
    localparam int FQ_CW = 2;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW = 2;
    localparam int OQ_CW = 3;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef struct packed {
        logic              cmd;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  symbol;
        logic [BYTE_W-1:0] data_byte;
    } request_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             error;
        logic             last;
    } result_t;

    // Classified work for the back end: bits left-aligned, first bit on top.
    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  cnt;
        logic [SYM_W-1:0]  sym;
    } work_t;

endpackage

/* src/htd_front.sv */
// Front end: accepts request items, classifies them and queues the work.
// Depends on htd_pkg.
module htd_front #(
    parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  htd_pkg::request_t request,
    output logic              work_valid,
    input  logic              work_ready,
    output htd_pkg::work_t    work
);
    import htd_pkg::*;

    localparam int CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    work_t            q_reg [FQ_DEPTH];
    logic [FQ_AW-1:0] wp_reg;
    logic [FQ_AW-1:0] wp_next;
    logic [FQ_AW-1:0] rp_reg;
    logic [FQ_AW-1:0] rp_next;
    logic [FQ_CW-1:0] cnt_reg;
    logic [FQ_CW-1:0] cnt_next;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] shamt;
    work_t            cls;
    logic             take;
    logic             enq;
    logic             deq;

    assign full = (cnt_reg == FQ_CW'(FQ_DEPTH));
    assign take = push && !full;

    always_comb
    begin
        len_eff = (request.code_length > LEN_W'(CAP)) ? LEN_W'(CAP) : request.code_length;
        shamt = LEN_W'(CODE_W) - len_eff;
        if (request.cmd == CMD_DECODE)
        begin
            cls.op = OP_DECODE;
            cls.bits = {request.data_byte, (CODE_W-BYTE_W)'(0)};
            cls.cnt = LEN_W'(BYTE_W);
            cls.sym = request.symbol;
        end
        else
        begin
            cls.op = OP_INSERT;
            cls.bits = request.code_bits << shamt;
            cls.cnt = len_eff;
            cls.sym = request.symbol;
        end
    end

    // Drop zero-length inserts here: they leave no trace.
    assign enq = take && !(request.cmd == CMD_INSERT && request.code_length == '0);
    assign deq = work_valid && work_ready;
    assign work_valid = (cnt_reg != '0);
    assign work = q_reg[rp_reg];

    always_comb
    begin
        wp_next = enq ? wp_reg + FQ_AW'(1) : wp_reg;
        rp_next = deq ? rp_reg + FQ_AW'(1) : rp_reg;
        cnt_next = cnt_reg + FQ_CW'(enq) - FQ_CW'(deq);
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/htd_back.sv */
// Back end: walks the node store for insert and decode work, one bit a cycle
// unless a full result queue stalls it. Depends on htd_pkg; feeds htd_outq.
module htd_back #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            work_valid,
    output logic            work_ready,
    input  htd_pkg::work_t  work,
    output logic            res_push,
    output htd_pkg::result_t res_data,
    input  logic            oq_full
);
    import htd_pkg::*;

    localparam int IW = $clog2(NODE_COUNT);
    localparam int CW = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic [IW-1:0]    left;
        logic [IW-1:0]    right;
        logic [SYM_W-1:0] sym;
        logic             leaf;
    } node_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_INS   = 4'b0010,
        S_DEC   = 4'b0100,
        S_FLUSH = 4'b1000
    } state_t;

    node_t mem [NODE_COUNT];

    state_t            state_reg, state_next;
    node_t             root_reg, root_next;
    node_t             rd_data_reg;
    logic              rd_root_reg, rd_root_next;
    logic              fresh_reg, fresh_next;
    logic              arrived_reg, arrived_next;
    logic [IW-1:0]     ins_idx_reg, ins_idx_next;
    logic [IW-1:0]     walk_reg, walk_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [CODE_W-1:0] bits_reg, bits_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;
    logic [CW-1:0]     nc_reg, nc_next;
    logic              halted_reg, halted_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0]  pend_sym_reg, pend_sym_next;
    logic              pend_err_reg, pend_err_next;
    logic              err_follow_reg, err_follow_next;

    node_t         cur;
    node_t         eff;
    node_t         wr_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          bit_b;
    logic [IW-1:0] link;
    logic          link_zero;
    logic          store_full;
    logic          leaf_hit;
    logic          new_res;
    logic [SYM_W-1:0] new_sym;
    logic          new_err;
    logic          stall;

    always_comb
    begin
        cur = fresh_reg ? '0 : (rd_root_reg ? root_reg : rd_data_reg);
        leaf_hit = (state_reg == S_DEC) && arrived_reg && cur.leaf;
        eff = leaf_hit ? root_reg : cur;
        bit_b = bits_reg[CODE_W-1];
        link = bit_b ? eff.right : eff.left;
        link_zero = (link == '0);
        store_full = (nc_reg == CW'(NODE_COUNT));
    end

    always_comb
    begin
        state_next = state_reg;
        root_next = root_reg;
        rd_root_next = rd_root_reg;
        fresh_next = fresh_reg;
        arrived_next = arrived_reg;
        ins_idx_next = ins_idx_reg;
        walk_next = walk_reg;
        cnt_next = cnt_reg;
        bits_next = bits_reg;
        sym_next = sym_reg;
        nc_next = nc_reg;
        halted_next = halted_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next = pend_sym_reg;
        pend_err_next = pend_err_reg;
        err_follow_next = err_follow_reg;
        wr_en = 1'b0;
        wr_addr = ins_idx_reg;
        wr_data = cur;
        rd_en = 1'b0;
        rd_addr = link;
        work_ready = 1'b0;
        res_push = 1'b0;
        res_data = '0;
        new_res = 1'b0;
        new_sym = '0;
        new_err = 1'b0;
        stall = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                work_ready = 1'b1;
                if (work_valid)
                begin
                    cnt_next = work.cnt;
                    bits_next = work.bits;
                    sym_next = work.sym;
                    fresh_next = 1'b0;
                    arrived_next = 1'b0;
                    if (work.op == OP_INSERT)
                    begin
                        ins_idx_next = '0;
                        rd_root_next = 1'b1;
                        state_next = S_INS;
                    end
                    else if (!halted_reg)
                    begin
                        if (walk_reg == '0)
                        begin
                            rd_root_next = 1'b1;
                        end
                        else
                        begin
                            rd_en = 1'b1;
                            rd_addr = walk_reg;
                            rd_root_next = 1'b0;
                        end
                        state_next = S_DEC;
                    end
                end
            end

            S_INS:
            begin
                if (cnt_reg == '0)
                begin
                    wr_en = 1'b1;
                    wr_data.sym = sym_reg;
                    wr_data.leaf = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!link_zero)
                begin
                    ins_idx_next = link;
                    rd_en = 1'b1;
                    rd_root_next = 1'b0;
                    fresh_next = 1'b0;
                    cnt_next = cnt_reg - LEN_W'(1);
                    bits_next = bits_reg << 1;
                end
                else if (store_full)
                begin
                    // Keep any freshly made node in the store before stopping.
                    wr_en = 1'b1;
                    halted_next = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_sym_next = '0;
                    pend_err_next = 1'b1;
                    err_follow_next = 1'b0;
                    state_next = S_FLUSH;
                end
                else
                begin
                    wr_en = 1'b1;
                    if (bit_b)
                    begin
                        wr_data.right = nc_reg[IW-1:0];
                    end
                    else
                    begin
                        wr_data.left = nc_reg[IW-1:0];
                    end
                    ins_idx_next = nc_reg[IW-1:0];
                    fresh_next = 1'b1;
                    rd_root_next = 1'b0;
                    nc_next = nc_reg + CW'(1);
                    cnt_next = cnt_reg - LEN_W'(1);
                    bits_next = bits_reg << 1;
                end
            end

            S_DEC:
            begin
                if (leaf_hit)
                begin
                    new_res = 1'b1;
                    new_sym = cur.sym;
                end
                else if (cnt_reg != '0 && link_zero)
                begin
                    new_res = 1'b1;
                    new_err = 1'b1;
                end
                stall = new_res && pend_valid_reg && oq_full;
                if (!stall)
                begin
                    if (new_res)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_push = 1'b1;
                            res_data.out_symbol = pend_sym_reg;
                            res_data.error = pend_err_reg;
                            res_data.last = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next = new_sym;
                        pend_err_next = new_err;
                    end
                    if (leaf_hit)
                    begin
                        walk_next = '0;
                    end
                    if (cnt_reg == '0)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (link_zero)
                    begin
                        halted_next = 1'b1;
                        walk_next = '0;
                        err_follow_next = leaf_hit;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        walk_next = link;
                        rd_en = 1'b1;
                        rd_root_next = 1'b0;
                        arrived_next = 1'b1;
                        cnt_next = cnt_reg - LEN_W'(1);
                        bits_next = bits_reg << 1;
                    end
                end
            end

            S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    if (!oq_full)
                    begin
                        res_push = 1'b1;
                        res_data.out_symbol = pend_sym_reg;
                        res_data.error = pend_err_reg;
                        res_data.last = !err_follow_reg;
                        if (err_follow_reg)
                        begin
                            pend_sym_next = '0;
                            pend_err_next = 1'b1;
                            err_follow_next = 1'b0;
                        end
                        else
                        begin
                            pend_valid_next = 1'b0;
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en && wr_addr == '0)
        begin
            root_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_addr != '0)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        ins_idx_reg <= ins_idx_next;
        bits_reg <= bits_next;
        sym_reg <= sym_next;
        pend_sym_reg <= pend_sym_next;
        pend_err_reg <= pend_err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            root_reg <= '0;
            rd_root_reg <= 1'b1;
            fresh_reg <= 1'b0;
            arrived_reg <= 1'b0;
            walk_reg <= '0;
            cnt_reg <= '0;
            nc_reg <= CW'(1);
            halted_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            err_follow_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            root_reg <= root_next;
            rd_root_reg <= rd_root_next;
            fresh_reg <= fresh_next;
            arrived_reg <= arrived_next;
            walk_reg <= walk_next;
            cnt_reg <= cnt_next;
            nc_reg <= nc_next;
            halted_reg <= halted_next;
            pend_valid_reg <= pend_valid_next;
            err_follow_reg <= err_follow_next;
        end
    end

endmodule

/* src/htd_outq.sv */
// Result queue: holds finished result items until they are popped.
// Depends on htd_pkg.
module htd_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_push,
    input  htd_pkg::result_t res_data,
    output logic             oq_full,
    output logic             empty,
    input  logic             pop,
    output htd_pkg::result_t result
);
    import htd_pkg::*;

    result_t          q_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wp_reg, wp_next;
    logic [OQ_AW-1:0] rp_reg, rp_next;
    logic [OQ_CW-1:0] cnt_reg, cnt_next;
    logic             enq;
    logic             deq;

    assign oq_full = (cnt_reg == OQ_CW'(OQ_DEPTH));
    assign empty = (cnt_reg == '0);
    assign result = q_reg[rp_reg];
    assign enq = res_push && !oq_full;
    assign deq = pop && !empty;

    always_comb
    begin
        wp_next = enq ? wp_reg + OQ_AW'(1) : wp_reg;
        rp_next = deq ? rp_reg + OQ_AW'(1) : rp_reg;
        cnt_next = cnt_reg + OQ_CW'(enq) - OQ_CW'(deq);
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wp_reg] <= res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/huffman_tree_decoder.sv */
// Huffman tree decoder top level: front queue, tree-walk back end, result queue.
// Depends on htd_pkg, htd_front, htd_back and htd_outq.
//
// Insert items build the code tree in a node store of NODE_COUNT entries; decode
// items walk it one coded bit per cycle, except where a full result queue stalls
// them, most significant bit of the byte first, and each symbol reached, or one
// error when a child is missing or the store runs out, comes out as a result item
// with last set on the final one of its item. After an error, decode items give
// nothing until reset, and a decode item taken while halted is dropped. A missing
// child stops a byte at that bit, a symbol and an error can come from the same
// bit, and a full store ends an insert early. The node store has a single read
// port.
// Two request items queue ahead of the back end and four results behind it, so push
// is refused only when that queue is full. The root node lives in flip-flops, so no
// clearing pass follows reset.
module huffman_tree_decoder #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF,
    parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  htd_pkg::request_t request,
    output logic              empty,
    input  logic              pop,
    output htd_pkg::result_t  result
);
    import htd_pkg::*;

    work_t   work;
    logic    work_valid;
    logic    work_ready;
    logic    res_push;
    result_t res_data;
    logic    oq_full;

    htd_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .work_valid (work_valid),
        .work_ready (work_ready),
        .work       (work)
    );

    htd_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (work_valid),
        .work_ready (work_ready),
        .work       (work),
        .res_push   (res_push),
        .res_data   (res_data),
        .oq_full    (oq_full)
    );

    htd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .oq_full  (oq_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

/* src/htd_checker.sv */
// Port-level checks for the Huffman tree decoder, bound to its top level.
// Depends on htd_pkg.
module htd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input htd_pkg::request_t request,
    input logic              empty,
    input logic              pop,
    input htd_pkg::result_t  result
);
    import htd_pkg::*;

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.error |-> result.last)
        else $error("error item not marked last");

    a_err_sym: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && result.error |-> result.out_symbol == '0)
        else $error("error item carries a symbol");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        !full && !push |=> !full)
        else $error("request queue filled without a push");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result item changed");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);
